[src/ctu_pkg.sv]
// Shared types and constants for the C subset tokenizer.
package ctu_pkg;

  // Counter widths and identifier prefix depth
  localparam int OFFSET_BITS   = 20;
  localparam int LINE_BITS     = 16;
  localparam int KEYWORD_CHARS = 6;
  localparam int PREFIX_IDX_W  = $clog2(KEYWORD_CHARS);

  // Fixed field widths of a result word
  localparam int KIND_W   = 5;
  localparam int START_W  = 20;
  localparam int LENGTH_W = 16;
  localparam int LINE_W   = 16;
  localparam int VALUE_W  = 31;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Lexer modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_OPER   = 2'd3;

  // Operators that wait one byte for a partner
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_BANG  = 3'd1;
  localparam logic [2:0] OP_ASSIGN = 3'd2;
  localparam logic [2:0] OP_LT    = 3'd3;
  localparam logic [2:0] OP_GT    = 3'd4;
  localparam logic [2:0] OP_AMP   = 3'd5;
  localparam logic [2:0] OP_BAR   = 3'd6;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_INT     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_VOID    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_IF      = 5'd2;
  localparam logic [KIND_W-1:0] KIND_ELSE    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_WHILE   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_RETURN  = 5'd5;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd6;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd7;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_STAR    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd11;
  localparam logic [KIND_W-1:0] KIND_NOT     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_NE      = 5'd13;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_EQ      = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LT      = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LE      = 5'd17;
  localparam logic [KIND_W-1:0] KIND_GT      = 5'd18;
  localparam logic [KIND_W-1:0] KIND_GE      = 5'd19;
  localparam logic [KIND_W-1:0] KIND_ANDAND  = 5'd20;
  localparam logic [KIND_W-1:0] KIND_OROR    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd22;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd23;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd24;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd25;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd26;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd27;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 5'd28;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 5'd29;
  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd30;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd31;

  // Keyword spellings, zero padded, and their lengths
  localparam int NUM_KEYWORDS = 6;
  localparam int KW_MAX_LEN   = 6;
  typedef logic [7:0] kw_text_t [KW_MAX_LEN];
  localparam kw_text_t KW_TEXT [NUM_KEYWORDS] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},  // void
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}   // return
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd6};

  // One result word
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic [LINE_W-1:0]   line;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } tok_t;

endpackage

[src/ctu_lexer.sv]
// Lexer state and per-byte next-state logic; yields up to two result words per byte.
module ctu_lexer import ctu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] text_byte,
  output logic [1:0] push_cnt,
  output tok_t       tok0,
  output tok_t       tok1
);

  logic [1:0]             mode_r, mode_nxt;
  logic [2:0]             pend_r, pend_nxt;
  logic [7:0]             prefix_r [KEYWORD_CHARS];
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_W-1:0]    run_r, run_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;

  logic                    pw_en;
  logic [PREFIX_IDX_W-1:0] pw_idx;
  logic [7:0]              pw_data;

  logic is_letter, is_digit, is_blank;
  logic [3:0] digit;
  logic [OFFSET_BITS-1:0] offset_adv;
  logic [LENGTH_W-1:0]    run_adv;
  logic [VALUE_W+3:0]     acc_ext, acc10;
  logic [START_W-1:0]     offset_out, start_out;
  logic [LINE_W-1:0]      line_out;
  logic [OFFSET_BITS+START_W-1:0] offset_wide, start_wide;
  logic [LINE_BITS+LINE_W-1:0]    line_wide;
  logic [NUM_KEYWORDS-1:0] kw_hit;
  logic [KIND_W-1:0]       ident_kind;
  logic fin_v, fr_v, go_fresh;
  tok_t fin_tok, fr_tok;

  // Classify the byte
  assign is_letter = (text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
  assign is_digit  = (text_byte inside {[8'h30:8'h39]});
  assign is_blank  = (text_byte inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
  assign digit     = text_byte[3:0];

  // Saturating counters and the decimal accumulator
  assign offset_adv = (offset_r == '1) ? offset_r : offset_r + OFFSET_BITS'(1);
  assign run_adv    = (run_r == '1) ? run_r : run_r + LENGTH_W'(1);
  assign acc_ext    = {4'b0, acc_r};
  assign acc10      = (acc_ext << 3) + (acc_ext << 1) + (VALUE_W+4)'(digit);

  // Fit counters to the result field widths
  assign offset_wide = {{START_W{1'b0}}, offset_r};
  assign start_wide  = {{START_W{1'b0}}, start_r};
  assign line_wide   = {{LINE_W{1'b0}}, line_r};
  assign offset_out  = offset_wide[START_W-1:0];
  assign start_out   = start_wide[START_W-1:0];
  assign line_out    = line_wide[LINE_W-1:0];

  // Match the identifier against the keywords on exact length
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      kw_hit[k] = (run_r == LENGTH_W'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k]) && prefix_r[i] != KW_TEXT[k][i]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        ident_kind = KIND_W'(k);
      end
    end
  end

  // Next state and result words for one accepted byte
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    offset_nxt = offset_r;
    line_nxt   = line_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    acc_nxt    = acc_r;
    pw_en      = 1'b0;
    pw_idx     = '0;
    pw_data    = text_byte;
    fin_v      = 1'b0;
    fr_v       = 1'b0;
    go_fresh   = 1'b0;
    fin_tok    = '0;
    fr_tok     = '0;
    fin_tok.line = line_out;
    fr_tok.line  = line_out;

    if (fire) begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_letter || is_digit) begin
            if (run_r < LENGTH_W'(KEYWORD_CHARS)) begin
              pw_en  = 1'b1;
              pw_idx = run_r[PREFIX_IDX_W-1:0];
            end
            run_nxt    = run_adv;
            offset_nxt = offset_adv;
          end else begin
            fin_v          = 1'b1;
            fin_tok.kind   = ident_kind;
            fin_tok.start  = start_out;
            fin_tok.length = run_r;
            go_fresh       = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            acc_nxt    = (acc10 > (VALUE_W+4)'(VALUE_MAX)) ? VALUE_MAX : acc10[VALUE_W-1:0];
            run_nxt    = run_adv;
            offset_nxt = offset_adv;
          end else begin
            fin_v          = 1'b1;
            fin_tok.kind   = KIND_NUMBER;
            fin_tok.start  = start_out;
            fin_tok.length = run_r;
            fin_tok.value  = acc_r;
            go_fresh       = 1'b1;
          end
        end
        MODE_OPER: begin
          fin_v         = 1'b1;
          fin_tok.start = start_out;
          fin_tok.length = LENGTH_W'(2);
          // Pair with the pending operator, or close it as a single character
          case (pend_r)
            OP_BANG:   fin_tok.kind = (text_byte == 8'h3D) ? KIND_NE : KIND_NOT;
            OP_ASSIGN: fin_tok.kind = (text_byte == 8'h3D) ? KIND_EQ : KIND_ASSIGN;
            OP_LT:     fin_tok.kind = (text_byte == 8'h3D) ? KIND_LE : KIND_LT;
            OP_GT:     fin_tok.kind = (text_byte == 8'h3D) ? KIND_GE : KIND_GT;
            OP_AMP:    fin_tok.kind = (text_byte == 8'h26) ? KIND_ANDAND : KIND_UNKNOWN;
            OP_BAR:    fin_tok.kind = (text_byte == 8'h7C) ? KIND_OROR : KIND_UNKNOWN;
            default:   fin_tok.kind = KIND_UNKNOWN;
          endcase
          if (fin_tok.kind inside {KIND_NE, KIND_EQ, KIND_LE, KIND_GE,
                                   KIND_ANDAND, KIND_OROR}) begin
            mode_nxt   = MODE_IDLE;
            pend_nxt   = OP_NONE;
            offset_nxt = offset_adv;
          end else begin
            fin_tok.length = LENGTH_W'(1);
            go_fresh       = 1'b1;
          end
        end
        default: begin
          go_fresh = 1'b1;
        end
      endcase

      // Lex the byte on its own
      if (go_fresh) begin
        mode_nxt = MODE_IDLE;
        pend_nxt = OP_NONE;
        if (text_byte == 8'h00) begin
          fr_v         = 1'b1;
          fr_tok.kind  = KIND_EOF;
          fr_tok.start = offset_out;
          offset_nxt   = '0;
          line_nxt     = LINE_BITS'(1);
          start_nxt    = '0;
          run_nxt      = '0;
          acc_nxt      = '0;
        end else begin
          offset_nxt = offset_adv;
          if (is_blank) begin
            if (text_byte == 8'h0A && line_r != '1) begin
              line_nxt = line_r + LINE_BITS'(1);
            end
          end else if (is_letter) begin
            mode_nxt  = MODE_IDENT;
            start_nxt = offset_r;
            run_nxt   = LENGTH_W'(1);
            pw_en     = 1'b1;
            pw_idx    = '0;
          end else if (is_digit) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = offset_r;
            run_nxt   = LENGTH_W'(1);
            acc_nxt   = VALUE_W'(digit);
          end else begin
            fr_tok.start  = offset_out;
            fr_tok.length = LENGTH_W'(1);
            fr_tok.kind   = KIND_UNKNOWN;
            case (text_byte)
              8'h2B: fr_tok.kind = KIND_PLUS;
              8'h2D: fr_tok.kind = KIND_MINUS;
              8'h2A: fr_tok.kind = KIND_STAR;
              8'h2F: fr_tok.kind = KIND_SLASH;
              8'h3B: fr_tok.kind = KIND_SEMI;
              8'h2C: fr_tok.kind = KIND_COMMA;
              8'h28: fr_tok.kind = KIND_LPAREN;
              8'h29: fr_tok.kind = KIND_RPAREN;
              8'h7B: fr_tok.kind = KIND_LBRACE;
              8'h7D: fr_tok.kind = KIND_RBRACE;
              8'h5B: fr_tok.kind = KIND_LBRACK;
              8'h5D: fr_tok.kind = KIND_RBRACK;
              8'h21: pend_nxt = OP_BANG;
              8'h3D: pend_nxt = OP_ASSIGN;
              8'h3C: pend_nxt = OP_LT;
              8'h3E: pend_nxt = OP_GT;
              8'h26: pend_nxt = OP_AMP;
              8'h7C: pend_nxt = OP_BAR;
              default: fr_tok.kind = KIND_UNKNOWN;
            endcase
            if (pend_nxt != OP_NONE) begin
              mode_nxt  = MODE_OPER;
              start_nxt = offset_r;
            end else begin
              fr_v = 1'b1;
            end
          end
        end
      end
    end
  end

  // Order the words: a finished pending token goes first
  always_comb begin
    push_cnt = {1'b0, fin_v} + {1'b0, fr_v};
    tok0     = fin_v ? fin_tok : fr_tok;
    tok1     = fr_tok;
    tok0.last = !(fin_v && fr_v);
    tok1.last = 1'b1;
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pend_r   <= OP_NONE;
      offset_r <= '0;
      line_r   <= LINE_BITS'(1);
      start_r  <= '0;
      run_r    <= '0;
      acc_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      offset_r <= offset_nxt;
      line_r   <= line_nxt;
      start_r  <= start_nxt;
      run_r    <= run_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Identifier prefix bytes
  always_ff @(posedge clk) begin
    if (pw_en) begin
      prefix_r[pw_idx] <= pw_data;
    end
  end

  a_oper_has_op: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_OPER |-> pend_r != OP_NONE)
    else $error("operator mode without pending operator");

  a_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_OPER |-> pend_r == OP_NONE)
    else $error("pending operator outside operator mode");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && text_byte == 8'h00 |=> offset_r == '0 && line_r == LINE_BITS'(1)
      && mode_r == MODE_IDLE)
    else $error("counters not restarted after end of text");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && text_byte == 8'h00 |-> push_cnt != 2'd0)
    else $error("end of text gave no word");

endmodule

[src/ctu_tok_fifo.sv]
// Four-entry result queue that takes up to two words a cycle and gives one.
module ctu_tok_fifo import ctu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  tok_t       push0,
  input  tok_t       push1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output tok_t       out_tok
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  tok_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_one;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign room2     = cnt_r <= (PTR_W+1)'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_tok   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign wp_one    = wp_r + PTR_W'(1);

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push_cnt);
    rp_nxt  = pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_one] <= push1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> room2)
    else $error("push into a queue without room");

  a_push_limit: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd3)
    else $error("more than two words pushed");

endmodule

[src/c_subset_tokenizer_top.sv]
// Top level of the C subset tokenizer: input register, lexer and result queue.
//
//   port group  | dir | handshake          | payload
//   in_         | in  | in_valid/in_ready   | in_text_byte[7:0]
//   out_        | out | out_valid/out_ready | token kind, start, length, line, value, last
//
// A byte is held in the input register until the queue has room for two words,
// then the lexer updates its state and pushes zero, one or two words into a
// four-entry queue, whose registered head word is offered on the out_ ports.
// Bytes enter one per cycle while the queue holds at most two words. Over any
// run a byte yields at most one word on average, so with out_ready high input
// never stalls; only a stalled output fills the queue and drops in_ready.
// Reset (rst_n low, synchronous) clears all control state and counters.
module c_subset_tokenizer_top import ctu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_token_kind,
  output logic [START_W-1:0]  out_token_start,
  output logic [LENGTH_W-1:0] out_token_length,
  output logic [LINE_W-1:0]   out_token_line,
  output logic [VALUE_W-1:0]  out_number_value,
  output logic                out_last_of_run
);

  logic       ibuf_valid_r, ibuf_valid_nxt;
  logic [7:0] ibuf_byte_r;
  logic       fire, room2;
  logic [1:0] push_cnt;
  tok_t       tok0, tok1, out_tok;

  // Hand the buffered byte to the lexer when the queue has room
  assign fire     = ibuf_valid_r && room2;
  assign in_ready = !ibuf_valid_r || fire;

  always_comb begin
    ibuf_valid_nxt = ibuf_valid_r;
    if (in_valid && in_ready) begin
      ibuf_valid_nxt = 1'b1;
    end else if (fire) begin
      ibuf_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_valid_r <= 1'b0;
    end else begin
      ibuf_valid_r <= ibuf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibuf_byte_r <= in_text_byte;
    end
  end

  ctu_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (ibuf_byte_r),
    .push_cnt  (push_cnt),
    .tok0      (tok0),
    .tok1      (tok1)
  );

  ctu_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (tok0),
    .push1     (tok1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  // Split the head word onto the result ports
  assign out_token_kind   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_token_line   = out_tok.line;
  assign out_number_value = out_tok.value;
  assign out_last_of_run  = out_tok.last;

  a_fire_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> fire)
    else $error("words pushed without a byte");

  a_buffer_drains: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_valid |=> !ibuf_valid_r)
    else $error("input register kept a consumed byte");

  a_eof_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_EOF |-> out_token_length == '0 && out_last_of_run)
    else $error("end-of-text word malformed");

endmodule

[tb/c_subset_tokenizer_top_test.sv]
// Self-checking testbench for the C subset tokenizer top level.
module c_subset_tokenizer_top_test;
  import ctu_pkg::*;

  // Shadow lexer and the queue of token words it expects
  class token_board;
    logic [1:0]             mode;
    logic [2:0]             op_wait;
    logic [7:0]             prefix [KEYWORD_CHARS];
    logic [OFFSET_BITS-1:0] offset;
    logic [LINE_BITS-1:0]   line_no;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LENGTH_W-1:0]    run_len;
    logic [VALUE_W-1:0]     value;
    tok_t                   tokens [$];
    int                     failures;

    function new();
      mode      = MODE_IDLE;
      op_wait   = OP_NONE;
      offset    = '0;
      line_no   = LINE_BITS'(1);
      tok_start = '0;
      run_len   = '0;
      value     = '0;
      failures  = 0;
      foreach (prefix[i]) prefix[i] = 8'h00;
    endfunction

    function bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function void bump_offset();
      if (offset != '1) offset++;
    endfunction

    function void add_token(logic [KIND_W-1:0] k, logic [OFFSET_BITS-1:0] s,
                            logic [LENGTH_W-1:0] n, logic [VALUE_W-1:0] v);
      tok_t t;
      t.kind   = k;
      t.start  = s[START_W-1:0];
      t.length = n;
      t.line   = line_no[LINE_W-1:0];
      t.value  = v;
      t.last   = 1'b0;
      tokens.push_back(t);
    endfunction

    // Close an identifier, promoting exact keyword spellings
    function void close_name();
      logic [KIND_W-1:0] k;
      bit same;
      k = KIND_IDENT;
      for (int w = 0; w < NUM_KEYWORDS; w++) begin
        if (k == KIND_IDENT && run_len == KW_LEN[w]) begin
          same = 1'b1;
          for (int i = 0; i < KW_LEN[w]; i++)
            if (prefix[i] != KW_TEXT[w][i]) same = 1'b0;
          if (same) k = KIND_INT + KIND_W'(w);
        end
      end
      add_token(k, tok_start, run_len, '0);
    endfunction

    // Lex a byte with no token pending
    function void fresh_byte(logic [7:0] b);
      logic [KIND_W-1:0] k;
      logic [2:0] op;
      mode    = MODE_IDLE;
      op_wait = OP_NONE;
      if (b == 8'h00) begin
        add_token(KIND_EOF, offset, '0, '0);
        offset    = '0;
        line_no   = LINE_BITS'(1);
        tok_start = '0;
        run_len   = '0;
        value     = '0;
        return;
      end
      if (is_blank(b)) begin
        if (b == "\n" && line_no != '1) line_no++;
      end else if (is_letter(b)) begin
        mode      = MODE_IDENT;
        tok_start = offset;
        run_len   = LENGTH_W'(1);
        prefix[0] = b;
      end else if (is_digit(b)) begin
        mode      = MODE_NUMBER;
        tok_start = offset;
        run_len   = LENGTH_W'(1);
        value     = VALUE_W'(b - 8'h30);
      end else begin
        k  = KIND_UNKNOWN;
        op = OP_NONE;
        case (b)
          "+": k = KIND_PLUS;
          "-": k = KIND_MINUS;
          "*": k = KIND_STAR;
          "/": k = KIND_SLASH;
          ";": k = KIND_SEMI;
          ",": k = KIND_COMMA;
          "(": k = KIND_LPAREN;
          ")": k = KIND_RPAREN;
          "{": k = KIND_LBRACE;
          "}": k = KIND_RBRACE;
          "[": k = KIND_LBRACK;
          "]": k = KIND_RBRACK;
          "!": op = OP_BANG;
          "=": op = OP_ASSIGN;
          "<": op = OP_LT;
          ">": op = OP_GT;
          "&": op = OP_AMP;
          "|": op = OP_BAR;
          default: ;
        endcase
        if (op != OP_NONE) begin
          mode      = MODE_OPER;
          op_wait   = op;
          tok_start = offset;
        end else begin
          add_token(k, offset, LENGTH_W'(1), '0);
        end
      end
      bump_offset();
    endfunction

    // Note an accepted input word and queue the tokens it finishes
    function void note_byte(logic [7:0] b);
      int first;
      logic [63:0] wide;
      logic [KIND_W-1:0] single, k;
      bit paired;
      first = tokens.size();
      case (mode)
        MODE_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            if (run_len < KEYWORD_CHARS) prefix[run_len[PREFIX_IDX_W-1:0]] = b;
            if (run_len != '1) run_len++;
            bump_offset();
          end else begin
            close_name();
            fresh_byte(b);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b)) begin
            wide  = {33'd0, value} * 64'd10 + 64'(b - 8'h30);
            value = (wide > VALUE_MAX) ? VALUE_MAX : wide[VALUE_W-1:0];
            if (run_len != '1) run_len++;
            bump_offset();
          end else begin
            add_token(KIND_NUMBER, tok_start, run_len, value);
            fresh_byte(b);
          end
        end
        MODE_OPER: begin
          single = KIND_UNKNOWN;
          k      = KIND_UNKNOWN;
          paired = 1'b0;
          case (op_wait)
            OP_BANG: begin
              single = KIND_NOT;
              if (b == "=") begin paired = 1'b1; k = KIND_NE; end
            end
            OP_ASSIGN: begin
              single = KIND_ASSIGN;
              if (b == "=") begin paired = 1'b1; k = KIND_EQ; end
            end
            OP_LT: begin
              single = KIND_LT;
              if (b == "=") begin paired = 1'b1; k = KIND_LE; end
            end
            OP_GT: begin
              single = KIND_GT;
              if (b == "=") begin paired = 1'b1; k = KIND_GE; end
            end
            OP_AMP: if (b == "&") begin paired = 1'b1; k = KIND_ANDAND; end
            OP_BAR: if (b == "|") begin paired = 1'b1; k = KIND_OROR; end
            default: ;
          endcase
          if (paired) begin
            add_token(k, tok_start, LENGTH_W'(2), '0);
            mode    = MODE_IDLE;
            op_wait = OP_NONE;
            bump_offset();
          end else begin
            add_token(single, tok_start, LENGTH_W'(1), '0);
            fresh_byte(b);
          end
        end
        default: fresh_byte(b);
      endcase
      if (tokens.size() > first) tokens[tokens.size()-1].last = 1'b1;
    endfunction

    // Compare an output word with the oldest queued token
    function void check_token(tok_t got);
      tok_t want;
      if (tokens.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: kind=%0d start=%0d len=%0d line=%0d value=%0d last=%0d",
                   got.kind, got.start, got.length, got.line, got.value, got.last);
        return;
      end
      want = tokens.pop_front();
      if (got.kind !== want.kind || got.start !== want.start ||
          got.length !== want.length || got.line !== want.line ||
          got.value !== want.value || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected kind=%0d start=%0d len=%0d line=%0d value=%0d last=%0d",
                   want.kind, want.start, want.length, want.line, want.value, want.last);
          $display("          actual   kind=%0d start=%0d len=%0d line=%0d value=%0d last=%0d",
                   got.kind, got.start, got.length, got.line, got.value, got.last);
        end
      end
    endfunction

    function int outstanding();
      return tokens.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [7:0]          in_text_byte = 8'h00;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [KIND_W-1:0]   out_token_kind;
  logic [START_W-1:0]  out_token_start;
  logic [LENGTH_W-1:0] out_token_length;
  logic [LINE_W-1:0]   out_token_line;
  logic [VALUE_W-1:0]  out_number_value;
  logic                out_last_of_run;

  token_board sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  string keywords [6] = '{"int", "void", "if", "else", "while", "return"};
  string operators [24] = '{"+", "-", "*", "/", ";", ",", "(", ")", "{", "}", "[", "]",
                            "!=", "==", "<=", ">=", "&&", "||",
                            "!", "=", "<", ">", "&", "|"};

  c_subset_tokenizer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_line   (out_token_line),
    .out_number_value (out_number_value),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both handshakes; input first so expectations exist before checks
  always @(posedge clk) begin : watch
    tok_t seen;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_text_byte);
      if (out_valid && out_ready) begin
        seen.kind   = out_token_kind;
        seen.start  = out_token_start;
        seen.length = out_token_length;
        seen.line   = out_token_line;
        seen.value  = out_number_value;
        seen.last   = out_last_of_run;
        sb.check_token(seen);
      end
    end
  end

  // Offer one word, idling first at the sender rate, and hold until taken
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int pick;
    pick = $urandom_range(52);
    if (pick < 26) return 8'h61 + 8'(pick);
    if (pick < 52) return 8'h41 + 8'(pick - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Send one random piece of source text
  task automatic send_random_piece();
    int pick, len;
    string s;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_text(keywords[$urandom_range(5)]);
    end else if (pick < 30) begin
      if ($urandom_range(2) == 0) begin
        // near miss on a keyword
        s = keywords[$urandom_range(5)];
        if ($urandom_range(1)) begin
          send_text(s);
          send_byte($urandom_range(1) ? rand_letter() : rand_digit());
        end else begin
          send_text(s.substr(0, s.len() - 2));
        end
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 1);
        send_byte(rand_letter());
        repeat (len - 1) send_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter());
      end
    end else if (pick < 45) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(14, 10) : $urandom_range(9, 1);
      repeat (len) send_byte(rand_digit());
    end else if (pick < 65) begin
      send_text(operators[$urandom_range(23)]);
    end else if (pick < 80) begin
      case ($urandom_range(5))
        0: send_byte(" ");
        1: send_byte(8'd9);
        2: send_byte("\n");
        3: send_byte(8'd11);
        4: send_byte(8'd12);
        default: send_byte(8'd13);
      endcase
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(255, 1)));
    end else if (pick < 95) begin
      send_byte("\n");
    end else begin
      send_byte(8'h00);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int mark, waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (phase == 0) begin
        // pairs, lone operators, newline closing a name, high bytes, pending at end
        send_text("if(x<=9)&&!||&a\n");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("==>");
        send_byte(8'h00);
        // short statement, then end of text again
        send_text("x;");
        send_byte(8'h00);
      end
      mark = bytes_sent;
      while (bytes_sent - mark < 225) send_random_piece();
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for stray words
    waited = 0;
    while (sb.outstanding() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[c_subset_tokenizer_top] OK");
    end else begin
      $display("[c_subset_tokenizer_top] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(12 * 1000000);
    $display("[c_subset_tokenizer_top] ERROR");
    $finish;
  end

endmodule

[files.f]
src/ctu_pkg.sv
src/ctu_lexer.sv
src/ctu_tok_fifo.sv
src/c_subset_tokenizer_top.sv
tb/c_subset_tokenizer_top_test.sv
